FILE: rtl/gnf_pkg.sv
`timescale 1ns / 1ps
// gnf_pkg: shared types, constants and helpers of the grid neighbor fetch unit
// no dependencies; imported by every module of the block

package gnf_pkg;

    // grid geometry and value width
    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int VALUE_BITS  = 64;
    localparam int GRID_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_BITS   = $clog2(GRID_DEPTH);
    localparam int ROW_BITS    = $clog2(MAX_ROWS);
    localparam int COL_BITS    = $clog2(MAX_COLS);
    localparam int DIM_BITS    = 7;
    localparam int IDX_BITS    = 13;
    localparam int CELLS_BITS  = 2 * DIM_BITS;

    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // direction code of the queried cell itself
    localparam logic [3:0] DIR_SELF = 4'd8;

    // configuration register indexes
    localparam int          CFG_IDX_BITS  = 3;
    localparam int          CFG_DATA_BITS = 7;
    localparam logic [2:0]  CFG_NUM_ROWS  = 3'd0;
    localparam logic [2:0]  CFG_NUM_COLS  = 3'd1;
    localparam logic [2:0]  CFG_MOORE     = 3'd2;
    localparam logic [2:0]  CFG_ADD_SELF  = 3'd3;
    localparam logic [2:0]  CFG_WRAP      = 3'd4;

    // input item
    typedef struct packed {
        logic                    command;
        logic [IDX_BITS-1:0]     cell_index;
        logic [63:0]             write_value;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [63:0]             neighbor_value;
        logic                    is_missing;
        logic [3:0]              direction;
        logic                    last_of_query;
    } t_out_item;

    // effective configuration seen by front and back
    typedef struct packed {
        logic [DIM_BITS-1:0]     rows;
        logic [DIM_BITS-1:0]     cols;
        logic [CELLS_BITS-1:0]   cells;
        logic                    moore;
        logic                    add_self;
        logic                    wrap;
    } t_cfg;

    // classified command passed from front to back
    typedef struct packed {
        logic                    is_query;
        logic                    in_range;
        logic [ADDR_BITS-1:0]    addr;
        logic [ROW_BITS-1:0]     row;
        logic [COL_BITS-1:0]     col;
        logic [63:0]             value;
    } t_cmd;

    // zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] maxv);
        logic [DIM_BITS-1:0] res;
        if (v == '0) begin
            res = DIM_BITS'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: rtl/gnf_front.sv
`timescale 1ns / 1ps
// gnf_front: accepts input items, checks the index range and splits query
// indexes into row and column with a radix-2 divider; depends on gnf_pkg

module gnf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gnf_pkg::t_cfg    i_cfg,
    input  logic             i_push,
    output logic             o_full,
    input  gnf_pkg::t_in_item i_item,
    output logic             o_cmd_push,
    input  logic             i_cmd_full,
    output gnf_pkg::t_cmd    o_cmd
);
    import gnf_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [ADDR_BITS-1:0]   r_rem;
    logic [COL_BITS-1:0]    r_quo;
    logic [2:0]             r_step;

    logic                   idx_ok;
    logic [ADDR_BITS-1:0]   lin_addr;
    logic [ADDR_BITS-1:0]   trial;
    logic                   ge;
    logic [ADDR_BITS-1:0]   n_rem;
    logic [COL_BITS-1:0]    n_quo;

    // range check and zero-based address of the incoming item
    always_comb begin
        idx_ok   = (i_item.cell_index != '0) &&
                   ({1'b0, i_item.cell_index} <= i_cfg.cells);
        lin_addr = idx_ok ? ADDR_BITS'(i_item.cell_index - IDX_BITS'(1)) : '0;
    end

    // one quotient bit per cycle, quotient known to fit the column width
    always_comb begin
        trial = ADDR_BITS'({{(ADDR_BITS-DIM_BITS){1'b0}}, i_cfg.rows} << r_step);
        ge    = (r_rem >= trial);
        n_rem = ge ? (r_rem - trial) : r_rem;
        n_quo = r_quo;
        n_quo[r_step] = ge;
    end

    // control and item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_cmd.is_query <= (i_item.command == CMD_QUERY);
                        r_cmd.in_range <= idx_ok;
                        r_cmd.addr     <= lin_addr;
                        r_cmd.row      <= '0;
                        r_cmd.col      <= '0;
                        r_cmd.value    <= i_item.write_value & VALUE_MASK;
                        r_rem          <= lin_addr;
                        r_quo          <= '0;
                        r_step         <= 3'(COL_BITS - 1);
                        r_state        <= (i_item.command == CMD_QUERY) ? S_DIV : S_PUSH;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    if (r_step == '0) begin
                        r_cmd.row <= ROW_BITS'(n_rem);
                        r_cmd.col <= n_quo;
                        r_state   <= S_PUSH;
                    end else begin
                        r_step <= r_step - 3'd1;
                    end
                end
                S_PUSH: begin
                    if (!i_cmd_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_full     = (r_state != S_IDLE);
    assign o_cmd_push = (r_state == S_PUSH) && !i_cmd_full;
    assign o_cmd      = r_cmd;

endmodule

FILE: rtl/gnf_cmd_queue.sv
`timescale 1ns / 1ps
// gnf_cmd_queue: two-entry queue of classified commands between front and back
// depends on gnf_pkg

module gnf_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  gnf_pkg::t_cmd  i_data,
    input  logic           i_pop,
    output logic           o_empty,
    output gnf_pkg::t_cmd  o_data
);
    import gnf_pkg::*;

    t_cmd        r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

FILE: rtl/gnf_back.sv
`timescale 1ns / 1ps
// gnf_back: owns the grid memory, performs writes and steps through the
// neighbors of a query, at most one memory read per result; depends on gnf_pkg

module gnf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gnf_pkg::t_cfg     i_cfg,
    input  logic              i_cmd_valid,
    input  gnf_pkg::t_cmd     i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output gnf_pkg::t_out_item o_result
);
    import gnf_pkg::*;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR   = $clog2(OUT_DEPTH);

    // coordinate step codes
    localparam logic [1:0] ST_STAY  = 2'b00;
    localparam logic [1:0] ST_PLUS  = 2'b01;
    localparam logic [1:0] ST_MINUS = 2'b11;

    localparam logic [1:0] ROW_STEP [8] = '{ST_MINUS, ST_PLUS, ST_STAY, ST_STAY,
                                            ST_MINUS, ST_MINUS, ST_PLUS, ST_PLUS};
    localparam logic [1:0] COL_STEP [8] = '{ST_STAY, ST_STAY, ST_MINUS, ST_PLUS,
                                            ST_MINUS, ST_PLUS, ST_MINUS, ST_PLUS};

    // returns {outside, coordinate} for one step along a dimension
    function automatic logic [ROW_BITS:0] step_coord(input logic [ROW_BITS-1:0] c,
                                                     input logic [1:0] s,
                                                     input logic [DIM_BITS-1:0] dim,
                                                     input logic wrap);
        logic [ROW_BITS:0] res;
        logic [DIM_BITS-1:0] top;
        top = dim - DIM_BITS'(1);
        case (s)
            ST_MINUS: begin
                if (c == '0) begin
                    res = wrap ? {1'b0, ROW_BITS'(top)} : {1'b1, {ROW_BITS{1'b0}}};
                end else begin
                    res = {1'b0, c - ROW_BITS'(1)};
                end
            end
            ST_PLUS: begin
                if ({1'b0, c} == top) begin
                    res = wrap ? '0 : {1'b1, {ROW_BITS{1'b0}}};
                end else begin
                    res = {1'b0, c + ROW_BITS'(1)};
                end
            end
            default: res = {1'b0, c};
        endcase
        return res;
    endfunction

    logic [63:0]           r_mem [GRID_DEPTH];
    logic [63:0]           r_rdata;

    logic                  r_busy;
    t_cmd                  r_query;
    logic [3:0]            r_idx;

    logic                  r_b_valid;
    logic                  r_b_miss;
    logic [3:0]            r_b_dir;
    logic                  r_b_last;

    t_out_item             r_out [OUT_DEPTH];
    logic [OUT_PTR-1:0]    r_wr_ptr;
    logic [OUT_PTR-1:0]    r_rd_ptr;
    logic [OUT_PTR:0]      r_count;

    logic [3:0]            ndir;
    logic [3:0]            nres;
    logic                  is_nbr;
    logic                  is_last;
    logic [3:0]            dir_code;
    logic [ROW_BITS:0]     row_res;
    logic [COL_BITS:0]     col_res;
    logic [12:0]           prod;
    logic [ADDR_BITS-1:0]  nb_addr;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic                  miss;
    logic                  issue;
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic                  out_pop;
    t_out_item             b_result;

    // result count and the current neighbor
    always_comb begin
        ndir     = i_cfg.moore ? 4'd8 : 4'd4;
        nres     = ndir + 4'(i_cfg.add_self);
        is_nbr   = (r_idx < ndir);
        is_last  = (r_idx == nres - 4'd1);
        dir_code = is_nbr ? r_idx : DIR_SELF;
        row_res  = step_coord(r_query.row, ROW_STEP[r_idx[2:0]], i_cfg.rows, i_cfg.wrap);
        col_res  = step_coord(r_query.col, COL_STEP[r_idx[2:0]], i_cfg.cols, i_cfg.wrap);
        prod     = {{(13-COL_BITS){1'b0}}, col_res[COL_BITS-1:0]} *
                   {{(13-DIM_BITS){1'b0}}, i_cfg.rows};
        nb_addr  = prod[ADDR_BITS-1:0] +
                   {{(ADDR_BITS-ROW_BITS){1'b0}}, row_res[ROW_BITS-1:0]};
        rd_addr  = is_nbr ? nb_addr : r_query.addr;
        miss     = !r_query.in_range ||
                   (is_nbr && (row_res[ROW_BITS] || col_res[COL_BITS]));
    end

    // handshakes toward the command queue and the result queue
    always_comb begin
        o_cmd_pop = !r_busy && i_cmd_valid;
        issue     = r_busy &&
                    (({1'b0, r_count} + {{OUT_PTR{1'b0}}, r_b_valid}) < (OUT_PTR+2)'(OUT_DEPTH));
        mem_we    = o_cmd_pop && !i_cmd.is_query && i_cmd.in_range;
        mem_addr  = r_busy ? rd_addr : i_cmd.addr;
        out_pop   = i_pop && (r_count != '0);
    end

    // grid memory, single port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_cmd.value;
        end
        if (issue && !miss) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // query sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= issue;
            if (o_cmd_pop && i_cmd.is_query) begin
                r_busy  <= 1'b1;
                r_idx   <= '0;
                r_query <= i_cmd;
            end else if (issue) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                end
            end
        end
    end

    // read stage payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_miss <= miss;
            r_b_dir  <= dir_code;
            r_b_last <= is_last;
        end
    end

    always_comb begin
        b_result.neighbor_value = r_b_miss ? '0 : r_rdata;
        b_result.is_missing     = r_b_miss;
        b_result.direction      = r_b_dir;
        b_result.last_of_query  = r_b_last;
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_out[r_wr_ptr] <= b_result;
        end
    end

    // result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_b_valid) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR'(1);
            end
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR'(1);
            end
            r_count <= r_count + (OUT_PTR+1)'(r_b_valid) - (OUT_PTR+1)'(out_pop);
        end
    end

    assign o_empty  = (r_count == '0);
    assign o_result = r_out[r_rd_ptr];

endmodule

FILE: rtl/grid_neighbor_fetch_unit.sv
`timescale 1ns / 1ps
// grid_neighbor_fetch_unit: top level, configuration registers and the
// front, command queue and back; depends on gnf_pkg, gnf_front,
// gnf_cmd_queue, gnf_back
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------
//  input     push / full          i_item   (command, cell_index, write_value)
//  result    pop / empty          o_result (value, is_missing, direction, last)
//  config    valid / ready        i_cfg_index, i_cfg_data
//
// a write transaction holds the front until its command is pushed; a query
// holds it through the one-bit-per-cycle row/column divider and the push state
// the back issues at most one grid memory read per result; a query yields
// nres results, nres = 4 or 8, plus 1 with add_self
// reset clears control state only; the grid memory content is undefined
// until written. a full result queue stalls the back, the two-entry
// command queue lets the front keep working meanwhile

module grid_neighbor_fetch_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  gnf_pkg::t_in_item                     i_item,
    output logic                                  empty,
    input  logic                                  pop,
    output gnf_pkg::t_out_item                    o_result,
    input  logic                                  valid,
    output logic                                  ready,
    input  logic [gnf_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [gnf_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import gnf_pkg::*;

    logic [DIM_BITS-1:0]    r_num_rows;
    logic [DIM_BITS-1:0]    r_num_cols;
    logic                   r_moore;
    logic                   r_add_self;
    logic                   r_wrap;

    t_cfg                   cfg;
    logic                   front_push;
    logic                   front_full;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    t_cmd                   front_cmd;
    t_cmd                   q_cmd;

    assign ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_BITS'(64);
            r_num_cols <= DIM_BITS'(64);
            r_moore    <= 1'b1;
            r_add_self <= 1'b0;
            r_wrap     <= 1'b0;
        end else if (valid && ready) begin
            unique case (i_cfg_index)
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                CFG_MOORE:    r_moore    <= i_cfg_data[0];
                CFG_ADD_SELF: r_add_self <= i_cfg_data[0];
                CFG_WRAP:     r_wrap     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective dimensions and cell count
    always_comb begin
        cfg.rows     = clamp_dim(r_num_rows, DIM_BITS'(MAX_ROWS));
        cfg.cols     = clamp_dim(r_num_cols, DIM_BITS'(MAX_COLS));
        cfg.cells    = {{DIM_BITS{1'b0}}, cfg.rows} * {{DIM_BITS{1'b0}}, cfg.cols};
        cfg.moore    = r_moore;
        cfg.add_self = r_add_self;
        cfg.wrap     = r_wrap;
    end

    gnf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push && !front_full),
        .o_full     (front_full),
        .i_item     (i_item),
        .o_cmd_push (front_push),
        .i_cmd_full (q_full),
        .o_cmd      (front_cmd)
    );

    gnf_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .o_full  (q_full),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_cmd)
    );

    gnf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (!q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    assign full = front_full;

    // an accepted transaction makes the front busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("front took a second transaction back to back");

    // a missing neighbor always carries a zero value
    a_missing_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.is_missing |-> o_result.neighbor_value == '0)
        else $error("missing result with nonzero value");

    // direction codes stay within the neighbor and self codes
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_result.direction <= DIR_SELF)
        else $error("direction code out of range");

endmodule

FILE: tb/tb_grid_neighbor_fetch_unit.sv
`timescale 1ns / 1ps
// tb_grid_neighbor_fetch_unit: self-checking bench for the grid neighbor fetch unit
// drives write and query transactions under many grid shapes and compares every
// neighbor result with a predicted one; depends on gnf_pkg and grid_neighbor_fetch_unit

module tb_grid_neighbor_fetch_unit;
    import gnf_pkg::*;

    // neighbor direction codes, the queried cell itself is DIR_SELF
    typedef enum logic [3:0] {
        DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT,
        DIR_UP_LEFT, DIR_UP_RIGHT, DIR_DOWN_LEFT, DIR_DOWN_RIGHT
    } t_dir;

    localparam int MAX_INDEX = (1 << IDX_BITS) - 1;
    localparam int MAX_CFG_INDEX = (1 << CFG_IDX_BITS) - 1;
    localparam int SETTLE_CYCLES = 40;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    t_in_item                 i_item = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    t_out_item                o_result;
    logic                     valid = 1'b0;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    // shadow of the configuration registers, at their reset values
    logic [DIM_BITS-1:0] cfg_rows = DIM_BITS'(64);
    logic [DIM_BITS-1:0] cfg_cols = DIM_BITS'(64);
    logic                cfg_moore = 1'b1;
    logic                cfg_self = 1'b0;
    logic                cfg_wrap = 1'b0;

    logic [63:0] grid_shadow [GRID_DEPTH];
    bit          cell_written [GRID_DEPTH];
    t_in_item    cmd_backlog [$];
    t_out_item   due_neighbors [$];

    logic cmd_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   run_left = 0;
    int   stall_left = 0;
    int   items_made = 0;
    int   cmds_accepted = 0;
    int   queries_accepted = 0;
    int   results_checked = 0;
    int   mismatches = 0;
    int   setups = 0;

    grid_neighbor_fetch_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .valid       (valid),
        .ready       (ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // dimension as the block uses it: zero counts as one, large values saturate
    function automatic int dim_in_use(input logic [DIM_BITS-1:0] v, input int limit);
        int w;
        w = int'(v);
        if (w == 0) return 1;
        if (w > limit) return limit;
        return w;
    endfunction

    function automatic int cells_in_use();
        return dim_in_use(cfg_rows, MAX_ROWS) * dim_in_use(cfg_cols, MAX_COLS);
    endfunction

    // linear address of one neighbor of cell p, hit low when it falls off the grid
    function automatic void neighbor_addr(input int p, input int d, input int rows,
                                          input int cols, input logic wrap,
                                          output logic hit, output int addr);
        int nr;
        int nc;
        nr = p % rows;
        nc = p / rows;
        case (d)
            DIR_UP, DIR_UP_LEFT, DIR_UP_RIGHT:       nr = nr - 1;
            DIR_DOWN, DIR_DOWN_LEFT, DIR_DOWN_RIGHT: nr = nr + 1;
            default: ;
        endcase
        case (d)
            DIR_LEFT, DIR_UP_LEFT, DIR_DOWN_LEFT:    nc = nc - 1;
            DIR_RIGHT, DIR_UP_RIGHT, DIR_DOWN_RIGHT: nc = nc + 1;
            default: ;
        endcase
        if (wrap) begin
            nr = (nr + rows) % rows;
            nc = (nc + cols) % cols;
        end
        hit = (nr >= 0) && (nr < rows) && (nc >= 0) && (nc < cols);
        addr = nc * rows + nr;
    endfunction

    // apply one accepted transaction to the grid copy and queue its neighbor results
    function automatic void fetch_neighbors(input t_in_item it);
        int rows;
        int cols;
        int idx;
        int p;
        int ndir;
        int nres;
        int d;
        int addr;
        logic in_grid;
        logic hit;
        t_out_item res;
        rows = dim_in_use(cfg_rows, MAX_ROWS);
        cols = dim_in_use(cfg_cols, MAX_COLS);
        idx = int'(it.cell_index);
        in_grid = (idx >= 1) && (idx <= rows * cols);
        if (it.command == CMD_WRITE) begin
            if (in_grid) grid_shadow[idx - 1] = it.write_value & VALUE_MASK;
            return;
        end
        queries_accepted++;
        ndir = cfg_moore ? 8 : 4;
        nres = ndir + (cfg_self ? 1 : 0);
        p = in_grid ? idx - 1 : 0;
        for (d = 0; d < nres; d++) begin
            res = '0;
            res.is_missing = 1'b1;
            res.direction = (d < ndir) ? 4'(d) : DIR_SELF;
            res.last_of_query = (d == nres - 1);
            if (in_grid) begin
                if (d < ndir) begin
                    neighbor_addr(p, d, rows, cols, cfg_wrap, hit, addr);
                    if (hit) begin
                        res.neighbor_value = grid_shadow[addr];
                        res.is_missing = 1'b0;
                    end
                end else begin
                    res.neighbor_value = grid_shadow[p];
                    res.is_missing = 1'b0;
                end
            end
            due_neighbors.insert(due_neighbors.size(), res);
        end
    endfunction

    // stimulus helpers
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // in-range cell, leaning toward the grid edges
    function automatic int pick_cell();
        int rows;
        int cols;
        int r;
        int c;
        rows = dim_in_use(cfg_rows, MAX_ROWS);
        cols = dim_in_use(cfg_cols, MAX_COLS);
        r = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 0 : rows - 1)
                                 : $urandom_range(0, rows - 1);
        c = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? 0 : cols - 1)
                                 : $urandom_range(0, cols - 1);
        return c * rows + r + 1;
    endfunction

    function automatic int pick_stray();
        return $urandom_range(0, 2) == 0 ? 0 : $urandom_range(cells_in_use() + 1, MAX_INDEX);
    endfunction

    function automatic void add_write(input int idx, input logic [63:0] v);
        t_in_item it;
        it.command = CMD_WRITE;
        it.cell_index = IDX_BITS'(idx);
        it.write_value = v;
        cmd_backlog.insert(cmd_backlog.size(), it);
        if (idx >= 1 && idx <= cells_in_use()) begin
            cell_written[idx - 1] = 1'b1;
            items_made++;
        end
    endfunction

    // a query first gets writes for every cell it will read that holds no value yet
    function automatic void add_query(input int idx);
        t_in_item it;
        int rows;
        int cols;
        int ndir;
        int d;
        int addr;
        logic hit;
        rows = dim_in_use(cfg_rows, MAX_ROWS);
        cols = dim_in_use(cfg_cols, MAX_COLS);
        ndir = cfg_moore ? 8 : 4;
        if (idx >= 1 && idx <= rows * cols) begin
            for (d = 0; d < ndir; d++) begin
                neighbor_addr(idx - 1, d, rows, cols, cfg_wrap, hit, addr);
                if (hit && !cell_written[addr]) add_write(addr + 1, pick_value());
            end
            if (cfg_self && !cell_written[idx - 1]) add_write(idx, pick_value());
        end
        it.command = CMD_QUERY;
        it.cell_index = IDX_BITS'(idx);
        it.write_value = {$urandom, $urandom};
        cmd_backlog.insert(cmd_backlog.size(), it);
        items_made++;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!ready);
    endtask

    // write all registers, single-bit ones with random upper data bits
    task automatic apply_setup(input int rows, input int cols, input logic moore,
                               input logic self_on, input logic wrap);
        write_reg(CFG_NUM_ROWS, CFG_DATA_BITS'(rows));
        write_reg(CFG_NUM_COLS, CFG_DATA_BITS'(cols));
        write_reg(CFG_MOORE, CFG_DATA_BITS'({$urandom_range(0, 63), moore}));
        write_reg(CFG_ADD_SELF, CFG_DATA_BITS'({$urandom_range(0, 63), self_on}));
        write_reg(CFG_WRAP, CFG_DATA_BITS'({$urandom_range(0, 63), wrap}));
        if ($urandom_range(0, 1))
            write_reg(CFG_IDX_BITS'($urandom_range(CFG_WRAP + 1, MAX_CFG_INDEX)),
                      CFG_DATA_BITS'($urandom));
        @(negedge i_clk);
        valid <= 1'b0;
        setups++;
    endtask

    // block idle: all transactions taken, all results seen, tail of the pipe flushed
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || push || due_neighbors.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_random(input int count);
        int goal;
        int r;
        goal = items_made + count;
        add_query(cells_in_use() + 1);
        while (items_made < goal) begin
            r = $urandom_range(0, 99);
            if (r < 65) add_query(pick_cell());
            else if (r < 85) add_write(pick_cell(), pick_value());
            else if (r < 93) add_query(pick_stray());
            else add_write(pick_stray(), pick_value());
        end
        wait_drained();
    endtask

    // main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset shape, ignored writes, out-of-range queries, corners
        add_write(0, '1);
        add_write(MAX_INDEX, '0);
        add_write(GRID_DEPTH + 1, pick_value());
        add_query(0);
        add_query(GRID_DEPTH + 1);
        add_query(MAX_INDEX);
        add_write(2, '1);
        add_write(MAX_ROWS + 1, '0);
        add_query(1);
        add_query(GRID_DEPTH);
        add_query(GRID_DEPTH / 2 + MAX_ROWS / 2);
        wait_drained();

        // shape extremes, clamped dimensions, torus on degenerate grids
        apply_setup(0, 127, 1'b0, 1'b1, 1'b1);
        fill_random(14);
        apply_setup(127, 0, 1'b1, 1'b1, 1'b1);
        fill_random(14);
        apply_setup(1, 1, 1'b1, 1'b1, 1'b0);
        fill_random(8);
        apply_setup(1, 1, 1'b1, 1'b1, 1'b1);
        fill_random(8);
        apply_setup(5, 7, 1'b1, 1'b0, 1'b1);
        fill_random(14);
        apply_setup(64, 64, 1'b0, 1'b0, 1'b0);
        fill_random(12);
        repeat (3) begin
            apply_setup($urandom_range(1, 9), $urandom_range(1, 9), 1'($urandom),
                        1'($urandom), 1'($urandom));
            fill_random(12);
        end

        $display("covered %0d input transactions (%0d queries) over %0d grid setups",
                 cmds_accepted, queries_accepted, setups + 1);
        $display("checked %0d neighbor results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // input transaction accepted: update the prediction
    always @(posedge i_clk) begin
        cmd_taken = i_rst_n && push && !full;
        if (cmd_taken) begin
            cmds_accepted++;
            fetch_neighbors(i_item);
        end
    end

    // configuration transaction accepted: update the shadow registers
    always @(posedge i_clk) begin
        if (i_rst_n && valid && ready) begin
            case (i_cfg_index)
                CFG_NUM_ROWS: cfg_rows = i_cfg_data;
                CFG_NUM_COLS: cfg_cols = i_cfg_data;
                CFG_MOORE:    cfg_moore = i_cfg_data[0];
                CFG_ADD_SELF: cfg_self = i_cfg_data[0];
                CFG_WRAP:     cfg_wrap = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // driver: bursts of transactions with random gaps, item held until taken
    always @(negedge i_clk) begin
        if (!(push && !cmd_taken)) begin
            if (cmd_taken) void'(cmd_backlog.pop_front());
            if (gap_left > 0) begin
                push <= 1'b0;
                gap_left--;
            end else if (cmd_backlog.size() != 0) begin
                push <= 1'b1;
                i_item <= cmd_backlog[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                               ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30)
                                                           : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // receiver: runs of pops broken by stalls, some long enough to back up the block
    always @(negedge i_clk) begin
        if (run_left > 0) begin
            pop <= 1'b1;
            run_left--;
        end else if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
        end else begin
            pop <= 1'b1;
            run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 6);
            stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 4);
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (due_neighbors.size() == 0) begin
                $error("unexpected result: value %h missing %b dir %0d last %b",
                       o_result.neighbor_value, o_result.is_missing,
                       o_result.direction, o_result.last_of_query);
                mismatches++;
            end else begin
                want = due_neighbors.pop_front();
                results_checked++;
                if (o_result.neighbor_value !== want.neighbor_value) begin
                    $error("neighbor_value: expected %h, got %h",
                           want.neighbor_value, o_result.neighbor_value);
                    mismatches++;
                end
                if (o_result.is_missing !== want.is_missing) begin
                    $error("is_missing: expected %b, got %b",
                           want.is_missing, o_result.is_missing);
                    mismatches++;
                end
                if (o_result.direction !== want.direction) begin
                    $error("direction: expected %0d, got %0d",
                           want.direction, o_result.direction);
                    mismatches++;
                end
                if (o_result.last_of_query !== want.last_of_query) begin
                    $error("last_of_query: expected %b, got %b",
                           want.last_of_query, o_result.last_of_query);
                    mismatches++;
                end
            end
        end
    end

endmodule
